### rtl/rcf_pkg.sv
// Shared types, register map and kernel arithmetic for the RGB 3x3 window filter.
package rcf_pkg;

    typedef logic [23:0] pix_t;
    typedef logic [8:0][7:0] chan_win_t;

    localparam logic [2:0] REG_FILTER_MODE  = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [2:0] REG_SEL_X_START  = 3'd3;
    localparam logic [2:0] REG_SEL_Y_START  = 3'd4;
    localparam logic [2:0] REG_SEL_X_END    = 3'd5;
    localparam logic [2:0] REG_SEL_Y_END    = 3'd6;

    localparam logic [1:0] MODE_EDGE    = 2'd0;
    localparam logic [1:0] MODE_SHARPEN = 2'd1;
    localparam logic [1:0] MODE_BOX     = 2'd2;
    localparam logic [1:0] MODE_GAUSS   = 2'd3;

    localparam logic [11:0] RECIP_NINE = 12'd3641;

    function automatic logic [7:0] chan_filter(input logic [1:0] mode, input chan_win_t px);
        logic [11:0]        sum_all;
        logic [10:0]        sum_edge;
        logic [10:0]        sum_corner;
        logic [11:0]        gsum;
        logic [23:0]        prod;
        logic signed [13:0] acc;
        logic [7:0]         res;
        sum_edge   = 11'(px[1]) + 11'(px[3]) + 11'(px[5]) + 11'(px[7]);
        sum_corner = 11'(px[0]) + 11'(px[2]) + 11'(px[6]) + 11'(px[8]);
        sum_all    = 12'(sum_edge) + 12'(sum_corner) + 12'(px[4]);
        gsum       = 12'(sum_corner) + {sum_edge, 1'b0} + {2'b00, px[4], 2'b00};
        prod       = 24'(sum_all) * 24'(RECIP_NINE);
        acc        = '0;
        res        = '0;
        case (mode)
            MODE_EDGE:
            begin
                acc = 14'(signed'({3'b000, px[4], 3'b000})) - 14'(signed'({1'b0, sum_all}))
                    + 14'(signed'({6'b0, px[4]}));
                acc = 14'(signed'({3'b000, px[4], 3'b000}))
                    - 14'(signed'({3'b000, sum_edge})) - 14'(signed'({3'b000, sum_corner}));
            end
            MODE_SHARPEN:
            begin
                acc = 14'(signed'({4'b0000, px[4], 2'b00})) + 14'(signed'({6'b0, px[4]}))
                    - 14'(signed'({3'b000, sum_edge}));
            end
            MODE_BOX:
            begin
                acc = 14'(signed'({5'b00000, prod[23:15]}));
            end
            default:
            begin
                acc = 14'(signed'({6'b000000, gsum[11:4]}));
            end
        endcase
        if (acc < 0)
        begin
            res = 8'd0;
        end
        else if (acc > 14'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = acc[7:0];
        end
        return res;
    endfunction

endpackage

### rtl/rcf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rgb_conv3x3_window_filter.sv
// RGB 3x3 convolution filter over a raster stream: line stores, window and kernel datapath.
// An accepted item reaches its result via the line store read, window and kernel stages.
// Throughput: 1 item per cycle unless stalled; line stores: 1 read and 1 write per cycle.
// A pixel is emitted image_width + 1 items after it enters; flush items drain the tail.
// Reset clears counters, window and valids, presets config; line store contents undefined.
module rgb_conv3x3_window_filter
    import rcf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [9:0]  out_col,
    output logic [11:0] out_row,
    output logic        last_pixel
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int EW = $clog2(MAX_HEIGHT);
    localparam int RW = $clog2(MAX_HEIGHT) + 1;

    logic [1:0]  filter_mode_reg;
    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [10:0] sel_x_start_reg;
    logic [12:0] sel_y_start_reg;
    logic [10:0] sel_x_end_reg;
    logic [12:0] sel_y_end_reg;

    logic          cfg_wr;
    logic [2:0]    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg  <= MODE_EDGE;
            image_width_reg  <= 11'd1024;
            image_height_reg <= 13'd4096;
            sel_x_start_reg  <= 11'd0;
            sel_y_start_reg  <= 13'd0;
            sel_x_end_reg    <= 11'd1024;
            sel_y_end_reg    <= 13'd4096;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_FILTER_MODE:  filter_mode_reg  <= pwdata[1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[12:0];
                REG_SEL_X_START:  sel_x_start_reg  <= pwdata[10:0];
                REG_SEL_Y_START:  sel_y_start_reg  <= pwdata[12:0];
                REG_SEL_X_END:    sel_x_end_reg    <= pwdata[10:0];
                REG_SEL_Y_END:    sel_y_end_reg    <= pwdata[12:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FILTER_MODE:  prdata = {30'd0, filter_mode_reg};
            REG_IMAGE_WIDTH:  prdata = {21'd0, image_width_reg};
            REG_IMAGE_HEIGHT: prdata = {19'd0, image_height_reg};
            REG_SEL_X_START:  prdata = {21'd0, sel_x_start_reg};
            REG_SEL_Y_START:  prdata = {19'd0, sel_y_start_reg};
            REG_SEL_X_END:    prdata = {21'd0, sel_x_end_reg};
            REG_SEL_Y_END:    prdata = {19'd0, sel_y_end_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // geometry limits
    logic [WW-1:0] w_lim;
    logic [WW-1:0] w_m1;
    logic [HW-1:0] h_lim;
    logic [HW-1:0] h_m1;

    always_comb
    begin
        if (image_width_reg == 11'd0)
        begin
            w_lim = WW'(1);
        end
        else if (32'(image_width_reg) > MAX_WIDTH)
        begin
            w_lim = WW'(MAX_WIDTH);
        end
        else
        begin
            w_lim = WW'(image_width_reg);
        end
        if (image_height_reg == 13'd0)
        begin
            h_lim = HW'(1);
        end
        else if (32'(image_height_reg) > MAX_HEIGHT)
        begin
            h_lim = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_lim = HW'(image_height_reg);
        end
        w_m1 = w_lim - WW'(1);
        h_m1 = h_lim - HW'(1);
    end

    // pipeline control
    logic advance;
    logic accept;
    logic proc;

    logic [CW-1:0] in_col_reg,   in_col_next;
    logic [RW-1:0] in_row_reg,   in_row_next;
    logic [CW-1:0] emit_col_reg, emit_col_next;
    logic [EW-1:0] emit_row_reg, emit_row_next;
    logic          received_reg, received_next;

    logic flush_eff;
    logic emit;
    logic last_now;
    logic sel_now;
    logic inner_now;

    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;
    assign proc     = accept && (received_reg || !req_type);

    assign flush_eff = req_type || received_reg;
    assign emit      = (in_row_reg >= RW'(2)) || (in_row_reg == RW'(1) && in_col_reg != '0);
    assign last_now  = (emit_col_reg >= w_m1) && (emit_row_reg >= h_m1);
    assign sel_now   = (emit_col_reg >= sel_x_start_reg) && (emit_col_reg < sel_x_end_reg)
                    && (emit_row_reg >= sel_y_start_reg) && (emit_row_reg < sel_y_end_reg);
    assign inner_now = (emit_col_reg != '0) && (emit_col_reg < w_m1)
                    && (emit_row_reg != '0) && (emit_row_reg < h_m1);

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        emit_col_next = emit_col_reg;
        emit_row_next = emit_row_reg;
        received_next = received_reg;
        if (in_col_reg >= w_m1)
        begin
            in_col_next = '0;
            if (!received_reg && in_row_reg >= h_m1)
            begin
                received_next = 1'b1;
            end
            if (in_row_reg != '1)
            begin
                in_row_next = in_row_reg + RW'(1);
            end
        end
        else
        begin
            in_col_next = in_col_reg + CW'(1);
        end
        if (emit)
        begin
            if (last_now)
            begin
                in_col_next   = '0;
                in_row_next   = '0;
                emit_col_next = '0;
                emit_row_next = '0;
                received_next = 1'b0;
            end
            else if (emit_col_reg >= w_m1)
            begin
                emit_col_next = '0;
                emit_row_next = emit_row_reg + EW'(1);
            end
            else
            begin
                emit_col_next = emit_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
            received_reg <= 1'b0;
        end
        else if (proc)
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            emit_col_reg <= emit_col_next;
            emit_row_reg <= emit_row_next;
            received_reg <= received_next;
        end
    end

    // stage A: line store read
    logic          a_valid_reg;
    logic [CW-1:0] a_idx_reg;
    pix_t          a_bot_reg;
    logic          a_emit_reg;
    logic          a_filt_reg;
    logic          a_last_reg;
    logic [CW-1:0] a_col_reg;
    logic [EW-1:0] a_row_reg;
    logic          fwd_reg;
    pix_t          fwd_top_reg;
    pix_t          fwd_mid_reg;

    pix_t q_above;
    pix_t q_two_above;
    pix_t a_top;
    pix_t a_mid;
    logic a_wr;

    assign a_top = fwd_reg ? fwd_top_reg : q_two_above;
    assign a_mid = fwd_reg ? fwd_mid_reg : q_above;
    assign a_wr  = a_valid_reg && advance;

    rcf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_row_above (
        .clk     (clk),
        .wr_en   (a_wr),
        .wr_addr (a_idx_reg),
        .wr_data (a_bot_reg),
        .rd_en   (proc),
        .rd_addr (in_col_reg),
        .rd_data (q_above)
    );

    rcf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_row_two_above (
        .clk     (clk),
        .wr_en   (a_wr),
        .wr_addr (a_idx_reg),
        .wr_data (a_mid),
        .rd_en   (proc),
        .rd_addr (in_col_reg),
        .rd_data (q_two_above)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= proc;
            fwd_reg     <= proc && a_valid_reg && (a_idx_reg == in_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_idx_reg   <= in_col_reg;
            a_bot_reg   <= flush_eff ? 24'd0 : {in_red, in_green, in_blue};
            a_emit_reg  <= emit;
            a_filt_reg  <= sel_now && inner_now;
            a_last_reg  <= last_now;
            a_col_reg   <= emit_col_reg;
            a_row_reg   <= emit_row_reg;
            fwd_top_reg <= a_mid;
            fwd_mid_reg <= a_bot_reg;
        end
    end

    // stage B: window
    pix_t [8:0]    win_reg;
    logic          b_valid_reg;
    logic          b_filt_reg;
    logic          b_last_reg;
    logic [CW-1:0] b_col_reg;
    logic [EW-1:0] b_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= '0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg && a_emit_reg;
            if (a_valid_reg)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= a_top;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= a_mid;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= a_bot_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_filt_reg <= a_filt_reg;
            b_last_reg <= a_last_reg;
            b_col_reg  <= a_col_reg;
            b_row_reg  <= a_row_reg;
        end
    end

    // stage C: kernel and result register
    chan_win_t px_r;
    chan_win_t px_g;
    chan_win_t px_b;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            px_r[k] = win_reg[k][23:16];
            px_g[k] = win_reg[k][15:8];
            px_b[k] = win_reg[k][7:0];
        end
    end

    logic       out_valid_reg;
    logic [7:0] out_red_reg;
    logic [7:0] out_green_reg;
    logic [7:0] out_blue_reg;
    logic [9:0] out_col_reg;
    logic [11:0] out_row_reg;
    logic       last_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_red_reg    <= b_filt_reg ? chan_filter(filter_mode_reg, px_r) : px_r[4];
            out_green_reg  <= b_filt_reg ? chan_filter(filter_mode_reg, px_g) : px_g[4];
            out_blue_reg   <= b_filt_reg ? chan_filter(filter_mode_reg, px_b) : px_b[4];
            out_col_reg    <= 10'(b_col_reg);
            out_row_reg    <= 12'(b_row_reg);
            last_pixel_reg <= b_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign last_pixel = last_pixel_reg;

endmodule

### verif/tb.sv
// Self-checking testbench for the RGB 3x3 window filter: APB setup, image and flush streams.
module tb
    import rcf_pkg::*;
();

    localparam int MAXW = 1024;
    localparam int MAXH = 4096;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [9:0]  out_col;
    logic [11:0] out_row;
    logic        last_pixel;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [9:0]  col;
        logic [11:0] row;
        logic        last;
    } pixel_out_t;

    pixel_out_t  pending_pixels[$];
    int          mismatch_count;
    bit          timed_out;
    int          stall_mode;

    logic [1:0]  cfg_mode;
    int unsigned cfg_width;
    int unsigned cfg_height;
    int unsigned cfg_x0;
    int unsigned cfg_y0;
    int unsigned cfg_x1;
    int unsigned cfg_y1;
    pix_t        line_above[MAXW];
    pix_t        line_two_above[MAXW];
    pix_t        win[9];
    int unsigned col_in;
    int unsigned row_in;
    int unsigned col_out;
    int unsigned row_out;
    bit          image_done;

    rgb_conv3x3_window_filter u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] kernel_sum(int sh);
        int kw[9];
        int acc;
        acc = 0;
        case (cfg_mode)
            MODE_EDGE:    kw = '{-1, -1, -1, -1, 8, -1, -1, -1, -1};
            MODE_SHARPEN: kw = '{0, -1, 0, -1, 5, -1, 0, -1, 0};
            MODE_BOX:     kw = '{1, 1, 1, 1, 1, 1, 1, 1, 1};
            default:      kw = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
        endcase
        for (int k = 0; k < 9; k++)
            acc += kw[k] * int'((win[k] >> sh) & 24'hFF);
        if (cfg_mode == MODE_BOX) acc = acc / 9;
        else if (cfg_mode == MODE_GAUSS) acc = acc / 16;
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        return acc[7:0];
    endfunction

    task automatic predict_pixel(input bit flush_req, input pix_t pix);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned idx;
        int unsigned ec;
        int unsigned er;
        bit          flush;
        bit          emit;
        bit          last;
        pix_t        top;
        pix_t        mid;
        pix_t        bot;
        pixel_out_t  res;
        w = clip(cfg_width, MAXW);
        h = clip(cfg_height, MAXH);
        flush = flush_req;
        c = col_in;
        r = row_in;
        idx = (c < MAXW) ? c : MAXW - 1;
        if (flush && !image_done) return;
        if (image_done) flush = 1'b1;
        top = line_two_above[idx];
        mid = line_above[idx];
        bot = flush ? '0 : pix;
        line_two_above[idx] = mid;
        line_above[idx] = bot;
        for (int y = 0; y < 3; y++)
        begin
            win[y*3] = win[y*3+1];
            win[y*3+1] = win[y*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = bot;
        emit = (r >= 2) || (r == 1 && c >= 1);
        if (c >= w - 1)
        begin
            col_in = 0;
            if (!image_done && r >= h - 1) image_done = 1'b1;
            row_in++;
        end
        else
            col_in++;
        if (!emit) return;
        ec = col_out;
        er = row_out;
        res.red = win[4][23:16];
        res.green = win[4][15:8];
        res.blue = win[4][7:0];
        last = (ec >= w - 1) && (er >= h - 1);
        if (ec >= cfg_x0 && ec < cfg_x1 && er >= cfg_y0 && er < cfg_y1
            && ec > 0 && ec < w - 1 && er > 0 && er < h - 1)
        begin
            res.red = kernel_sum(16);
            res.green = kernel_sum(8);
            res.blue = kernel_sum(0);
        end
        res.col = ec[9:0];
        res.row = er[11:0];
        res.last = last;
        pending_pixels.push_back(res);
        if (last)
        begin
            col_in = 0;
            row_in = 0;
            col_out = 0;
            row_out = 0;
            image_done = 1'b0;
        end
        else if (ec >= w - 1)
        begin
            col_out = 0;
            row_out++;
        end
        else
            col_out++;
    endtask

    task automatic write_reg(input logic [2:0] index, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_FILTER_MODE:  cfg_mode = value[1:0];
            REG_IMAGE_WIDTH:  cfg_width = value & 32'h7FF;
            REG_IMAGE_HEIGHT: cfg_height = value & 32'h1FFF;
            REG_SEL_X_START:  cfg_x0 = value & 32'h7FF;
            REG_SEL_Y_START:  cfg_y0 = value & 32'h1FFF;
            REG_SEL_X_END:    cfg_x1 = value & 32'h7FF;
            default:          cfg_y1 = value & 32'h1FFF;
        endcase
    endtask

    task automatic send_item(input bit flush, input pix_t pix, input bit bursty);
        if (bursty && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= flush;
        in_red <= pix[23:16];
        in_green <= pix[15:8];
        in_blue <= pix[7:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_pixel(flush, pix);
    endtask

    task automatic drain_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_frame(input int unsigned mode, input int unsigned w,
                             input int unsigned h, input int unsigned x0,
                             input int unsigned y0, input int unsigned x1,
                             input int unsigned y1);
        write_reg(REG_FILTER_MODE, mode);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_SEL_X_START, x0);
        write_reg(REG_SEL_Y_START, y0);
        write_reg(REG_SEL_X_END, x1);
        write_reg(REG_SEL_Y_END, y1);
    endtask

    // one full image plus its drain; kind picks pixel content, and kind 2 also slips in stray flush items
    task automatic run_image(input int kind, input bit bursty);
        int unsigned n;
        pix_t        pix;
        n = clip(cfg_width, MAXW) * clip(cfg_height, MAXH);
        for (int unsigned i = 0; i < n; i++)
        begin
            case (kind)
                0: pix = (i % 2) ? 24'hFFFFFF : 24'h000000;
                1: pix = (i % 3 == 0) ? 24'hFF00FF : 24'h00FF00;
                default: pix = 24'($urandom);
            endcase
            if (kind == 2 && $urandom_range(0, 15) == 0)
                send_item(1'b1, 24'($urandom), bursty);
            send_item(1'b0, pix, bursty);
        end
        for (int unsigned i = 0; i <= clip(cfg_width, MAXW); i++)
            send_item($urandom_range(0, 3) != 0, 24'($urandom), bursty);
        drain_idle();
    endtask

    task automatic test_directed();
        set_frame(MODE_EDGE, 4, 3, 0, 0, 1024, 4096);
        run_image(0, 1'b0);
        set_frame(MODE_SHARPEN, 3, 4, 0, 0, 1024, 4096);
        run_image(1, 1'b0);
        send_item(1'b1, 24'h123456, 1'b0);
        drain_idle();
    endtask

    task automatic test_modes();
        for (int m = 0; m < 4; m++)
        begin
            set_frame(m, $urandom_range(3, 8), $urandom_range(3, 6), 0, 0, 1024, 4096);
            run_image(2, 1'b1);
        end
    endtask

    task automatic test_geometry();
        set_frame(MODE_BOX, 1, 1, 0, 0, 0, 0);
        run_image(2, 1'b1);
        set_frame(MODE_GAUSS, 0, 0, 1024, 4096, 1024, 4096);
        run_image(2, 1'b1);
        set_frame(MODE_GAUSS, 100, 1, 2047, 8191, 2047, 8191);
        run_image(2, 1'b1);
        set_frame(MODE_EDGE, 40, 4, 1, 0, 39, 4096);
        run_image(2, 1'b1);
    endtask

    task automatic test_random();
        for (int k = 0; k < 18; k++)
        begin
            stall_mode = $urandom_range(0, 2);
            set_frame($urandom_range(0, 3), $urandom_range(1, 9), $urandom_range(1, 7),
                      $urandom_range(0, 4), $urandom_range(0, 4),
                      $urandom_range(2, 10), $urandom_range(2, 8));
            run_image(2, k % 3 != 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        req_type = 1'b0;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        mismatch_count = 0;
        timed_out = 1'b0;
        stall_mode = 1;
        cfg_mode = MODE_EDGE;
        cfg_width = 1024;
        cfg_height = 4096;
        cfg_x0 = 0;
        cfg_y0 = 0;
        cfg_x1 = 1024;
        cfg_y1 = 4096;
        for (int i = 0; i < MAXW; i++)
        begin
            line_above[i] = '0;
            line_two_above[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        col_in = 0;
        row_in = 0;
        col_out = 0;
        row_out = 0;
        image_done = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_modes();
        test_geometry();
        test_random();
        if (mismatch_count == 0 && !timed_out)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        pixel_out_t exp_px;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected pixel col %0d row %0d", out_col, out_row);
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                if (exp_px.red !== out_red || exp_px.green !== out_green
                    || exp_px.blue !== out_blue || exp_px.col !== out_col
                    || exp_px.row !== out_row || exp_px.last !== last_pixel)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp %h %h %h c%0d r%0d l%0d got %h %h %h c%0d r%0d l%0d",
                                 exp_px.red, exp_px.green, exp_px.blue, exp_px.col,
                                 exp_px.row, exp_px.last, out_red, out_green, out_blue,
                                 out_col, out_row, last_pixel);
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end
endmodule
